@@ rtl/core/rgmg_pkg.sv @@
package rgmg_pkg;

    // Field and register widths
    localparam int FIELD_W  = 20;
    localparam int WGT_W    = 17;
    localparam int WGT_FRAC = 16;
    localparam int IDX_W    = 2;

    // Internal widths that do not depend on the fraction size
    localparam int PROD_W = FIELD_W + WGT_W + 1;   // channel * weight
    localparam int SUM_W  = PROD_W + 1;            // sum of three products
    localparam int Y_W    = 23;                    // luminance
    localparam int D_W    = 24;                    // channel minus luminance
    localparam int MIX_W  = 26;                    // mixed channels and their max

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LUM_RED      = 2'd0,
        REG_LUM_GREEN    = 2'd1,
        REG_LUM_BLUE     = 2'd2,
        REG_SAT_PRESERVE = 2'd3
    } cfg_reg_t;

    localparam logic [WGT_W-1:0] RST_LUM_RED      = 17'd13933;
    localparam logic [WGT_W-1:0] RST_LUM_GREEN    = 17'd46871;
    localparam logic [WGT_W-1:0] RST_LUM_BLUE     = 17'd4732;
    localparam logic [WGT_W-1:0] RST_SAT_PRESERVE = 17'd6554;

    // Per-item data carried alongside the first divider bank
    typedef struct packed {
        logic                          last;
        logic [2:0]                    dneg;
        logic [2:0]                    dzero;
        logic [Y_W-1:0]                y;
        logic [2:0][FIELD_W-1:0]       c;
    } side_t;

    // Per-item data carried alongside the output divider bank
    typedef struct packed {
        logic       last;
        logic [2:0] neg;
    } out_side_t;

endpackage

@@ rtl/core/rgmg_div.sv @@
module rgmg_div #(
    parameter int NW = 49,
    parameter int DW = 23,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    // Pipelined restoring divider, one quotient bit per stage.
    // Quotients of 2^QW or more saturate to all ones.
    localparam int RW = NW - QW;
    localparam int CW = ((RW > DW) ? RW : DW) + 1;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          ovf_reg [0:QW];

    logic [CW-1:0] top_next;
    logic          ovf_next;

    // Upper numerator bits decide overflow up front
    always_comb
    begin
        top_next = CW'(num[NW-1:QW]);
        ovf_next = (top_next >= CW'(den));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf_next ? '0 : DW'(top_next);
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
            diff  = trial - {1'b0, den_reg[k-1]};
            take  = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k] <= low_reg[k-1] << 1;
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], take};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = ovf_reg[QW] ? '1 : quo_reg[QW];

endmodule

@@ rtl/core/rgb_gamut_map_to_gray.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  in_red, in_green, in_blue, in_last
// output    out        out_valid / out_stall out_red, out_green, out_blue, out_last
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// One item per cycle is accepted while in_stall is low; the pipeline holds FRAC_BITS + 17
// stages of the reciprocal divider bank, 21 stages of the rescale divider bank, 13 others.
// Reset clears the valid bits, the skid buffer and loads the default weights.
// A stalled result moves into a one-item skid register; while it is full the whole
// pipeline holds and in_stall is high, so nothing is dropped or repeated.
module rgb_gamut_map_to_gray #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rgmg_pkg::IDX_W-1:0]          cfg_index,
    input  logic [rgmg_pkg::WGT_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rgmg_pkg::FIELD_W-1:0] in_red,
    input  logic signed [rgmg_pkg::FIELD_W-1:0] in_green,
    input  logic signed [rgmg_pkg::FIELD_W-1:0] in_blue,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rgmg_pkg::FIELD_W-1:0] out_red,
    output logic signed [rgmg_pkg::FIELD_W-1:0] out_green,
    output logic signed [rgmg_pkg::FIELD_W-1:0] out_blue,
    output logic                                out_last
);

    import rgmg_pkg::*;

    localparam int VW   = FRAC_BITS + 16;                 // saturating datapath width
    localparam int QW1  = VW;
    localparam int NW1  = ((2 * FRAC_BITS > FRAC_BITS + 20) ? 2 * FRAC_BITS
                                                           : FRAC_BITS + 20) + 1;
    localparam int DW1  = D_W - 1;
    localparam int QW2  = FIELD_W;
    localparam int NW2  = FRAC_BITS + MIX_W;
    localparam int DW2  = MIX_W;
    localparam int MPW  = VW + 1 + WGT_W + 1;
    localparam int PMW  = FRAC_BITS + 2 + D_W;
    localparam int NV   = QW1 + QW2 + 15;

    localparam logic signed [VW-1:0] DP_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] DP_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_V  =
        {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // Configuration registers
    logic [WGT_W-1:0] wgt_red_reg, wgt_green_reg, wgt_blue_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_red_reg   <= RST_LUM_RED;
            wgt_green_reg <= RST_LUM_GREEN;
            wgt_blue_reg  <= RST_LUM_BLUE;
            sat_reg       <= RST_SAT_PRESERVE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LUM_RED:      wgt_red_reg   <= cfg_data;
                REG_LUM_GREEN:    wgt_green_reg <= cfg_data;
                REG_LUM_BLUE:     wgt_blue_reg  <= cfg_data;
                REG_SAT_PRESERVE: sat_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Global advance: the pipeline holds only while the skid register is full
    logic          skid_full_reg;
    logic          adv;
    logic [NV-1:0] vld_reg;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NV-2:0], in_valid};
    end

    // Stage 1: channel times weight
    logic signed [FIELD_W-1:0] p1_c_reg    [3];
    logic signed [PROD_W-1:0]  p1_prod_reg [3];
    logic                      p1_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_c_reg[0]    <= in_red;
            p1_c_reg[1]    <= in_green;
            p1_c_reg[2]    <= in_blue;
            p1_prod_reg[0] <= in_red   * $signed({1'b0, wgt_red_reg});
            p1_prod_reg[1] <= in_green * $signed({1'b0, wgt_green_reg});
            p1_prod_reg[2] <= in_blue  * $signed({1'b0, wgt_blue_reg});
            p1_last_reg    <= in_last;
        end
    end

    // Stage 2: luminance, rounded
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   ysh_next;
    logic signed [Y_W-1:0]     p2_y_reg;
    logic signed [FIELD_W-1:0] p2_c_reg [3];
    logic                      p2_last_reg;

    always_comb
    begin
        sum_next = SUM_W'(p1_prod_reg[0]) + SUM_W'(p1_prod_reg[1])
                 + SUM_W'(p1_prod_reg[2]) + SUM_W'(32768);
        ysh_next = sum_next >>> WGT_FRAC;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_y_reg    <= ysh_next[Y_W-1:0];
            p2_c_reg    <= p1_c_reg;
            p2_last_reg <= p1_last_reg;
        end
    end

    // Stage 3: channel minus luminance
    logic signed [D_W-1:0]     p3_d_reg [3];
    logic signed [Y_W-1:0]     p3_y_reg;
    logic signed [FIELD_W-1:0] p3_c_reg [3];
    logic                      p3_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                p3_d_reg[i] <= D_W'(p2_c_reg[i]) - D_W'(p2_y_reg);
            p3_y_reg    <= p2_y_reg;
            p3_c_reg    <= p2_c_reg;
            p3_last_reg <= p2_last_reg;
        end
    end

    // Stage 4: divider operands with half-divisor rounding offset
    logic [D_W-1:0]     dabs_next [3];
    logic [FIELD_W-1:0] cabs_next [3];
    logic [NW1-1:0]     ninv_next [3];
    logic [NW1-1:0]     nvov_next [3];
    side_t              side_next;

    logic [DW1-1:0]     p4_ud_reg   [3];
    logic [NW1-1:0]     p4_ninv_reg [3];
    logic [NW1-1:0]     p4_nvov_reg [3];
    side_t              p4_side_reg;

    always_comb
    begin
        side_next.last = p3_last_reg;
        side_next.y    = p3_y_reg;
        for (int i = 0; i < 3; i++)
        begin
            dabs_next[i] = p3_d_reg[i][D_W-1] ? -p3_d_reg[i] : p3_d_reg[i];
            cabs_next[i] = p3_c_reg[i][FIELD_W-1] ? -p3_c_reg[i] : p3_c_reg[i];
            ninv_next[i] = (NW1'(1) << (2 * FRAC_BITS))
                         + NW1'(dabs_next[i][DW1-1:1]);
            nvov_next[i] = (NW1'(cabs_next[i]) << FRAC_BITS)
                         + NW1'(dabs_next[i][DW1-1:1]);
            side_next.dneg[i]  = p3_d_reg[i][D_W-1];
            side_next.dzero[i] = (p3_d_reg[i] == '0);
            side_next.c[i]     = p3_c_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p4_ud_reg[i]   <= dabs_next[i][DW1-1:0];
                p4_ninv_reg[i] <= ninv_next[i];
                p4_nvov_reg[i] <= nvov_next[i];
            end
            p4_side_reg <= side_next;
        end
    end

    // Reciprocal and v/(v-y) divider bank
    logic [QW1-1:0] q_inv [3];
    logic [QW1-1:0] q_vov [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_div1
        rgmg_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_inv (
            .clk (clk),
            .en  (adv),
            .num (p4_ninv_reg[g]),
            .den (p4_ud_reg[g]),
            .quo (q_inv[g])
        );
        rgmg_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_vov (
            .clk (clk),
            .en  (adv),
            .num (p4_nvov_reg[g]),
            .den (p4_ud_reg[g]),
            .quo (q_vov[g])
        );
    end

    side_t side1_reg [0:QW1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg[0] <= p4_side_reg;
            for (int k = 1; k <= QW1; k++)
                side1_reg[k] <= side1_reg[k-1];
        end
    end

    // Stage 5: signed, saturated quotients and their difference
    side_t              s5_side;
    logic signed [VW-1:0] inv_next [3];
    logic signed [VW-1:0] vov_next [3];
    logic signed [VW:0]   dfw_next [3];
    logic signed [VW-1:0] dif_next [3];
    logic                 vneg_next [3];

    logic signed [VW-1:0] p5_vov_reg [3];
    logic signed [VW-1:0] p5_dif_reg [3];
    side_t                p5_side_reg;

    assign s5_side = side1_reg[QW1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vneg_next[i] = s5_side.c[i][FIELD_W-1] ^ s5_side.dneg[i];
            if (s5_side.dzero[i])
            begin
                inv_next[i] = ONE_V;
                vov_next[i] = VW'($signed(s5_side.c[i]));
            end
            else
            begin
                if (q_inv[i][QW1-1])
                    inv_next[i] = s5_side.dneg[i] ? DP_MIN : DP_MAX;
                else
                    inv_next[i] = s5_side.dneg[i] ? -$signed(q_inv[i]) : $signed(q_inv[i]);
                if (q_vov[i][QW1-1])
                    vov_next[i] = vneg_next[i] ? DP_MIN : DP_MAX;
                else
                    vov_next[i] = vneg_next[i] ? -$signed(q_vov[i]) : $signed(q_vov[i]);
            end
            dfw_next[i] = (VW+1)'(vov_next[i]) - (VW+1)'(inv_next[i]);
            if (dfw_next[i][VW] != dfw_next[i][VW-1])
                dif_next[i] = dfw_next[i][VW] ? DP_MIN : DP_MAX;
            else
                dif_next[i] = dfw_next[i][VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_vov_reg  <= vov_next;
            p5_dif_reg  <= dif_next;
            p5_side_reg <= s5_side;
        end
    end

    // Stage 6: gray saturation and gray luminance maxima
    logic signed [VW-1:0] gs_next, gl_next, cand_next;
    logic signed [VW-1:0] p6_gs_reg, p6_gl_reg;
    side_t                p6_side_reg;

    always_comb
    begin
        gs_next   = '0;
        gl_next   = '0;
        cand_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (p5_side_reg.dneg[i] && (p5_vov_reg[i] > gs_next))
                gs_next = p5_vov_reg[i];
            cand_next = (p5_side_reg.dneg[i] || p5_side_reg.dzero[i]) ? gs_next
                                                                      : p5_dif_reg[i];
            if (cand_next > gl_next)
                gl_next = cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_gs_reg   <= gs_next;
            p6_gl_reg   <= gl_next;
            p6_side_reg <= p5_side_reg;
        end
    end

    // Stage 7: blend product
    logic signed [VW:0]    gd_next;
    logic signed [MPW-1:0] p7_mp_reg;
    logic signed [VW-1:0]  p7_gl_reg;
    side_t                 p7_side_reg;

    assign gd_next = (VW+1)'(p6_gs_reg) - (VW+1)'(p6_gl_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_mp_reg   <= gd_next * $signed({1'b0, sat_reg});
            p7_gl_reg   <= p6_gl_reg;
            p7_side_reg <= p6_side_reg;
        end
    end

    // Stage 8: clamped mix, and y - v per channel
    logic signed [MPW-1:0]    mpr_next, mixw_next;
    logic [FRAC_BITS:0]       mix_next;
    logic [FRAC_BITS:0]       p8_mix_reg;
    logic signed [D_W-1:0]    p8_e_reg [3];
    side_t                    p8_side_reg;

    always_comb
    begin
        mpr_next  = (p7_mp_reg + MPW'(32768)) >>> WGT_FRAC;
        mixw_next = mpr_next + MPW'(p7_gl_reg);
        if (mixw_next < 0)
            mix_next = '0;
        else if (mixw_next > MPW'(ONE_V))
            mix_next = ONE_V[FRAC_BITS:0];
        else
            mix_next = mixw_next[FRAC_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_mix_reg <= mix_next;
            for (int i = 0; i < 3; i++)
                p8_e_reg[i] <= D_W'($signed(p7_side_reg.y)) - D_W'($signed(p7_side_reg.c[i]));
            p8_side_reg <= p7_side_reg;
        end
    end

    // Stage 9: mix times (y - v)
    logic signed [PMW-1:0] p9_pm_reg [3];
    side_t                 p9_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                p9_pm_reg[i] <= $signed({1'b0, p8_mix_reg}) * p8_e_reg[i];
            p9_side_reg <= p8_side_reg;
        end
    end

    // Stage 10: mixed channels
    logic signed [PMW-1:0]   pmr_next [3];
    logic signed [MIX_W-1:0] p10_mixed_reg [3];
    logic                    p10_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pmr_next[i] = (p9_pm_reg[i] + (PMW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                p10_mixed_reg[i] <= MIX_W'(pmr_next[i]) + MIX_W'($signed(p9_side_reg.c[i]));
            p10_last_reg <= p9_side_reg.last;
        end
    end

    // Stage 11: max(1, mixed channels)
    logic signed [MIX_W-1:0] maxv_next;
    logic signed [MIX_W-1:0] p11_maxv_reg;
    logic signed [MIX_W-1:0] p11_mixed_reg [3];
    logic                    p11_last_reg;

    always_comb
    begin
        maxv_next = MIX_W'(ONE_V);
        for (int i = 0; i < 3; i++)
            if (p10_mixed_reg[i] > maxv_next)
                maxv_next = p10_mixed_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p11_maxv_reg  <= maxv_next;
            p11_mixed_reg <= p10_mixed_reg;
            p11_last_reg  <= p10_last_reg;
        end
    end

    // Stage 12: rescale divider operands
    logic [MIX_W-1:0] mabs_next [3];
    logic [NW2-1:0]   p12_num_reg [3];
    logic [DW2-1:0]   p12_den_reg;
    out_side_t        p12_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mabs_next[i] = p11_mixed_reg[i][MIX_W-1] ? -p11_mixed_reg[i] : p11_mixed_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p12_num_reg[i] <= (NW2'(mabs_next[i]) << FRAC_BITS)
                                + NW2'(p11_maxv_reg[MIX_W-1:1]);
                p12_side_reg.neg[i] <= p11_mixed_reg[i][MIX_W-1];
            end
            p12_den_reg       <= p11_maxv_reg;
            p12_side_reg.last <= p11_last_reg;
        end
    end

    // Rescale divider bank
    logic [QW2-1:0] q_out [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_div2
        rgmg_div #(.NW(NW2), .DW(DW2), .QW(QW2)) u_div_out (
            .clk (clk),
            .en  (adv),
            .num (p12_num_reg[g]),
            .den (p12_den_reg),
            .quo (q_out[g])
        );
    end

    out_side_t side2_reg [0:QW2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg[0] <= p12_side_reg;
            for (int k = 1; k <= QW2; k++)
                side2_reg[k] <= side2_reg[k-1];
        end
    end

    // Stage 13: sign and saturate to the field range
    logic signed [FIELD_W-1:0] res_next [3];
    logic signed [FIELD_W-1:0] res_reg  [3];
    logic                      res_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (side2_reg[QW2].neg[i])
                res_next[i] = q_out[i][QW2-1] ? FIELD_MIN : -$signed(q_out[i]);
            else
                res_next[i] = q_out[i][QW2-1] ? FIELD_MAX : $signed(q_out[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg      <= res_next;
            res_last_reg <= side2_reg[QW2].last;
        end
    end

    // Output skid register
    logic signed [FIELD_W-1:0] skid_reg [3];
    logic                      skid_last_reg;
    logic                      skid_full_next;
    logic                      skid_load;

    assign skid_load = !skid_full_reg && vld_reg[NV-1] && out_stall;

    always_comb
    begin
        if (skid_full_reg)
            skid_full_next = out_stall;
        else
            skid_full_next = skid_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else
            skid_full_reg <= skid_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (skid_load)
        begin
            skid_reg      <= res_reg;
            skid_last_reg <= res_last_reg;
        end
    end

    assign out_valid = skid_full_reg || vld_reg[NV-1];
    assign out_red   = skid_full_reg ? skid_reg[0]   : res_reg[0];
    assign out_green = skid_full_reg ? skid_reg[1]   : res_reg[1];
    assign out_blue  = skid_full_reg ? skid_reg[2]   : res_reg[2];
    assign out_last  = skid_full_reg ? skid_last_reg : res_last_reg;

endmodule

@@ rtl/core/rgmg_check.sv @@
module rgmg_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [rgmg_pkg::FIELD_W-1:0] out_red,
    input logic signed [rgmg_pkg::FIELD_W-1:0] out_green,
    input logic signed [rgmg_pkg::FIELD_W-1:0] out_blue,
    input logic                                out_last
);

    import rgmg_pkg::*;

    // Input is held back only after an item was refused at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("in_stall without a refused item");

    // An open output frees the input on the next cycle
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |=> !in_stall)
        else $error("in_stall held after output drained");

    // A refused item stays on the port unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
                                   && $stable(out_blue) && $stable(out_last))
        else $error("stalled item changed");

endmodule

bind rgb_gamut_map_to_gray rgmg_check u_rgmg_check (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import rgmg_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = FRAC + 51;
    localparam int IDLE_MAX  = 20000;
    localparam int N_RANDOM  = 1700;

    typedef struct {
        logic signed [FIELD_W-1:0] red;
        logic signed [FIELD_W-1:0] green;
        logic signed [FIELD_W-1:0] blue;
        logic                      last;
    } pixel_t;

    // Gamut map predictor and queue of expected mapped pixels
    class gamut_scoreboard;
        logic [WGT_W-1:0] wr, wg, wb, sat;
        pixel_t           pending[$];
        int               mismatches;

        function void reset_regs();
            wr = RST_LUM_RED;
            wg = RST_LUM_GREEN;
            wb = RST_LUM_BLUE;
            sat = RST_SAT_PRESERVE;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [WGT_W-1:0] val);
            case (idx)
                REG_LUM_RED:      wr = val;
                REG_LUM_GREEN:    wg = val;
                REG_LUM_BLUE:     wb = val;
                REG_SAT_PRESERVE: sat = val;
                default:          ;
            endcase
        endfunction

        // round(x / 2^s), ties toward plus infinity
        function longint rshift_round(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        // round(n / d), ties away from zero
        function longint div_away(longint n, longint d);
            longint un, ud, q;
            un = n < 0 ? -n : n;
            ud = d < 0 ? -d : d;
            q = (un + ud / 2) / ud;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function longint clip_dp(longint x);
            return clip(x, -(longint'(1) << (FRAC + 15)), (longint'(1) << (FRAC + 15)) - 1);
        endfunction

        function void note_input(pixel_t px);
            longint one, y, gs, gl, mix, maxv, d, inv, vov, cand;
            longint c[3];
            longint mixed[3];
            longint o[3];
            pixel_t res;
            one = longint'(1) << FRAC;
            c[0] = longint'(px.red);
            c[1] = longint'(px.green);
            c[2] = longint'(px.blue);
            y = rshift_round(c[0] * longint'(wr) + c[1] * longint'(wg)
                             + c[2] * longint'(wb), WGT_FRAC);
            gs = 0;
            gl = 0;
            for (int i = 0; i < 3; i++)
            begin
                d = c[i] - y;
                if (d == 0)
                begin
                    // channel on the luminance: reciprocal forced to one
                    inv = one;
                    vov = clip_dp(c[i]);
                end
                else
                begin
                    inv = clip_dp(div_away(one * one, d));
                    vov = clip_dp(div_away(c[i] * one, d));
                end
                if (d < 0 && vov > gs)
                    gs = vov;
                cand = d <= 0 ? gs : clip_dp(vov - inv);
                if (cand > gl)
                    gl = cand;
            end
            mix = clip(rshift_round(longint'(sat) * (gs - gl), WGT_FRAC) + gl, 0, one);
            maxv = one;
            for (int i = 0; i < 3; i++)
            begin
                mixed[i] = rshift_round(mix * (y - c[i]), FRAC) + c[i];
                if (mixed[i] > maxv)
                    maxv = mixed[i];
            end
            for (int i = 0; i < 3; i++)
                o[i] = clip(div_away(mixed[i] * one, maxv), -524288, 524287);
            res.red = FIELD_W'(o[0]);
            res.green = FIELD_W'(o[1]);
            res.blue = FIELD_W'(o[2]);
            res.last = px.last;
            pending.push_back(res);
        endfunction

        function void check_result(pixel_t got);
            pixel_t exp_px;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
                return;
            end
            exp_px = pending.pop_front();
            if (got.red !== exp_px.red || got.green !== exp_px.green
                || got.blue !== exp_px.blue || got.last !== exp_px.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp r=%0d g=%0d b=%0d l=%0b got r=%0d g=%0d b=%0d l=%0b",
                             exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                             got.red, got.green, got.blue, got.last);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [WGT_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [FIELD_W-1:0] in_red = '0;
    logic signed [FIELD_W-1:0] in_green = '0;
    logic signed [FIELD_W-1:0] in_blue = '0;
    logic                      in_last = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [FIELD_W-1:0] out_red;
    logic signed [FIELD_W-1:0] out_green;
    logic signed [FIELD_W-1:0] out_blue;
    logic                      out_last;

    gamut_scoreboard sb;
    int              idle_cycles = 0;
    bit              stall_free = 1'b0;

    always #5 clk = ~clk;

    rgb_gamut_map_to_gray #(.FRAC_BITS(FRAC)) DUT (.*);

    // Mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result monitor and acceptance watchdog
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.red = out_red;
                got.green = out_green;
                got.blue = out_blue;
                got.last = out_last;
                sb.check_result(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_free)
                out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
                n = $urandom_range(0, 99) < 10 ? 60 : $urandom_range(1, 6);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic send_pixel(logic signed [FIELD_W-1:0] r, logic signed [FIELD_W-1:0] g,
                              logic signed [FIELD_W-1:0] b, logic last);
        pixel_t px;
        int     n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_red <= r;
        in_green <= g;
        in_blue <= b;
        in_last <= last;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.last = last;
        do @(posedge clk); while (in_stall);
        sb.note_input(px);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [WGT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Random channel: mostly the normal range, sometimes the full field
    function logic signed [FIELD_W-1:0] rand_chan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FIELD_W'($urandom_range(0, 65536));
        if (r < 75) return -$signed({1'b0, 19'($urandom_range(0, 20000))});
        if (r < 80) return FIELD_MAX;
        if (r < 83) return FIELD_MIN;
        return FIELD_W'($urandom);
    endfunction

    task automatic random_burst(int count);
        logic signed [FIELD_W-1:0] r;
        for (int i = 0; i < count; i++)
        begin
            r = rand_chan();
            // some gray pixels so channels land on the luminance
            if ($urandom_range(0, 9) == 0)
                send_pixel(r, r, r, 1'($urandom_range(0, 1)));
            else
                send_pixel(r, rand_chan(), rand_chan(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [WGT_W-1:0] ext_vals[4];
        sb = new();
        sb.reset_regs();
        sb.mismatches = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, grays, single channels, saturation
        send_pixel(0, 0, 0, 1'b0);
        send_pixel(65536, 65536, 65536, 1'b1);
        send_pixel(FIELD_MAX, FIELD_MAX, FIELD_MAX, 1'b0);
        send_pixel(FIELD_MIN, FIELD_MIN, FIELD_MIN, 1'b1);
        send_pixel(FIELD_MAX, FIELD_MIN, 0, 1'b0);
        send_pixel(FIELD_MIN, FIELD_MAX, FIELD_MAX, 1'b1);
        send_pixel(65536, 0, 0, 1'b0);
        send_pixel(0, 65536, 0, 1'b0);
        send_pixel(0, 0, 65536, 1'b1);
        send_pixel(-1, -1, -1, 1'b0);
        send_pixel(-65536, 131072, 32768, 1'b0);
        send_pixel(200000, 10, -5000, 1'b1);
        send_pixel(1, 0, 0, 1'b0);
        send_pixel(-1, 1, -1, 1'b1);
        // pause until every pending result is out
        drain();

        // Config settings: zeros, all ones max, red weight and saturation at one, random, reset
        ext_vals = '{17'd0, 17'd0, 17'd0, 17'd0};
        for (int k = 0; k < 4; k++)
            write_cfg(cfg_reg_t'(k), ext_vals[k]);
        random_burst(60);
        drain();
        for (int k = 0; k < 4; k++)
            write_cfg(cfg_reg_t'(k), 17'h1FFFF);
        send_pixel(FIELD_MAX, FIELD_MIN, FIELD_MAX, 1'b1);
        random_burst(60);
        drain();
        write_cfg(REG_LUM_RED, 17'd65536);
        write_cfg(REG_LUM_GREEN, 17'd0);
        write_cfg(REG_LUM_BLUE, 17'd0);
        write_cfg(REG_SAT_PRESERVE, 17'd65536);
        random_burst(80);
        drain();
        for (int k = 0; k < 4; k++)
            write_cfg(cfg_reg_t'(k), WGT_W'($urandom_range(0, 17'h1FFFF)));
        random_burst(100);
        drain();
        write_cfg(REG_LUM_RED, RST_LUM_RED);
        write_cfg(REG_LUM_GREEN, RST_LUM_GREEN);
        write_cfg(REG_LUM_BLUE, RST_LUM_BLUE);
        write_cfg(REG_SAT_PRESERVE, RST_SAT_PRESERVE);

        // Bulk random at default weights, with a stretch of no stalls
        random_burst(700);
        stall_free = 1'b1;
        random_burst(300);
        stall_free = 1'b0;
        random_burst(400);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
